FILE: rtl/iidl_pkg.sv
`timescale 1ns / 1ps
// package for the indexed insert/delete list: field widths, request modes,
// status codes, default sizes and the per-cell control word; no dependencies
package iidl_pkg;

	// fixed widths of the request and response fields
	localparam int POS_W = 4;
	localparam int VAL_W = 32;
	localparam int CNT_W = 5;
	localparam int MODE_W = 2;
	localparam int ST_W = 2;

	// default sizes
	localparam int DEPTH_DEF = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// request modes
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ = 2'd2;
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd3;

	// response status codes
	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	// broadcast control to every cell of the row
	typedef struct packed {
		logic ins;
		logic del;
		logic wr;
	} cell_ctrl_t;

endpackage

FILE: rtl/iidl_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for requests and responses of the list
// depends on iidl_pkg for the field widths

interface iidl_req_if;
	logic valid;
	logic ready;
	logic [iidl_pkg::MODE_W-1:0] mode;
	logic [iidl_pkg::POS_W-1:0] position;
	logic signed [iidl_pkg::VAL_W-1:0] value;

	modport source (output valid, output mode, output position, output value, input ready);
	modport sink (input valid, input mode, input position, input value, output ready);
endinterface

interface iidl_rsp_if;
	logic valid;
	logic ready;
	logic signed [iidl_pkg::VAL_W-1:0] read_value;
	logic [iidl_pkg::CNT_W-1:0] count;
	logic [iidl_pkg::ST_W-1:0] status;

	modport source (output valid, output read_value, output count, output status, input ready);
	modport sink (input valid, input read_value, input count, input status, output ready);
endinterface

FILE: rtl/indexed_insert_delete_list.sv
`timescale 1ns / 1ps
// top level of the indexed insert/delete list: decode, cell row, response register
// depends on iidl_pkg, iidl_if and iidl_cell

// An ordered list of up to DEPTH words kept in a row of cells. Every request
// (insert, delete, read or write at a position) is checked against the fill
// count, all cells shift, load or hold together at the same edge, and the
// response word is registered, so it appears the cycle after the request is
// accepted. A new request is taken every cycle as long as the response
// register is empty or being drained, giving one word per cycle sustained; the
// fill count compare and the cell read mux set the cycle time. Insert at a
// position equal to the count appends. Only positions 0 to 15 can be addressed.
module indexed_insert_delete_list #(
	parameter int DEPTH = iidl_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = iidl_pkg::DATA_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	iidl_req_if.sink req,
	iidl_rsp_if.source rsp
);
	import iidl_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FC_W = $clog2(DEPTH + 1);
	localparam int K_W = FC_W + POS_W;
	localparam int CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;

	logic [FC_W-1:0] fill_q;
	logic [FC_W-1:0] fill_d;
	logic rsp_valid_q;
	logic signed [VAL_W-1:0] read_value_q;
	logic [CNT_W-1:0] count_q;
	logic [ST_W-1:0] status_q;

	logic acc;
	logic [K_W-1:0] pos_k;
	logic [K_W-1:0] fill_k;
	logic [ST_W-1:0] status_d;
	cell_ctrl_t ctrl;
	logic [CMP_W-1:0] pos_c;
	logic [DATA_WIDTH-1:0] word;
	logic [63:0] word_ext;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [63:0] rd_ext;
	logic signed [VAL_W-1:0] rd_d;
	logic [K_W+CNT_W-1:0] cnt_ext;

	// handshake: take a word when the response register is free or draining
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc = req.valid && req.ready;

	// range and full checks against the fill count
	assign pos_k = K_W'(req.position);
	assign fill_k = K_W'(fill_q);

	always_comb begin
		status_d = ST_OK;
		unique case (req.mode)
			MODE_INSERT: begin
				if (pos_k > fill_k) begin
					status_d = ST_RANGE;
				end else if (fill_k == K_W'(DEPTH)) begin
					status_d = ST_FULL;
				end
			end
			MODE_DELETE, MODE_READ, MODE_WRITE: begin
				if (pos_k >= fill_k) begin
					status_d = ST_RANGE;
				end
			end
		endcase
	end

	// control broadcast to the cell row
	always_comb begin
		ctrl.ins = acc && (req.mode == MODE_INSERT) && (status_d == ST_OK);
		ctrl.del = acc && (req.mode == MODE_DELETE) && (status_d == ST_OK);
		ctrl.wr = acc && (req.mode == MODE_WRITE) && (status_d == ST_OK);
	end

	// stored word is the sign-extended input cut to the cell width
	assign word_ext = 64'(req.value);
	assign word = word_ext[DATA_WIDTH-1:0];
	assign pos_c = CMP_W'(req.position);

	// row of cells, each fed by both neighbors
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[g+1];
		end
		iidl_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.CMP_W(CMP_W),
			.INDEX(g)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.pos(pos_c),
			.word(word),
			.left(left_w),
			.right(right_w),
			.data(cell_data[g])
		);
	end

	// read path: select the addressed cell and sign-extend to the output width
	assign rd_ext = 64'($signed(cell_data[pos_k[IDX_W-1:0]]));
	assign rd_d = ((req.mode == MODE_READ) && (status_d == ST_OK)) ? rd_ext[VAL_W-1:0] : '0;

	// next fill count
	always_comb begin
		fill_d = fill_q;
		if (ctrl.ins) begin
			fill_d = fill_q + FC_W'(1);
		end else if (ctrl.del) begin
			fill_d = fill_q - FC_W'(1);
		end
	end

	assign cnt_ext = (K_W + CNT_W)'(fill_d);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (acc) begin
			read_value_q <= rd_d;
			count_q <= cnt_ext[CNT_W-1:0];
			status_q <= status_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.count = count_q;
	assign rsp.status = status_q;

	// fill count never passes the capacity
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_k <= K_W'(DEPTH))
		else $error("fill count above capacity");

	// a successful insert grows the list by one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |=> (fill_q == $past(fill_q) + FC_W'(1)))
		else $error("insert did not grow the list");

	// a rejected request leaves the count untouched
	a_reject_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (status_d != ST_OK)) |=> $stable(fill_q))
		else $error("rejected request changed the count");

	// an accepted request always shows up as a pending response
	a_rsp_pending: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> rsp_valid_q)
		else $error("accepted word produced no response");

endmodule

FILE: rtl/iidl_cell.sv
`timescale 1ns / 1ps
// one storage cell of the list: shifts from a neighbor, loads or holds
// depends on iidl_pkg for the control word

module iidl_cell #(
	parameter int DATA_WIDTH = iidl_pkg::DATA_WIDTH_DEF,
	parameter int CMP_W = 8,
	parameter int INDEX = 0
) (
	input logic clk,
	input iidl_pkg::cell_ctrl_t ctrl,
	input logic [CMP_W-1:0] pos,
	input logic [DATA_WIDTH-1:0] word,
	input logic [DATA_WIDTH-1:0] left,
	input logic [DATA_WIDTH-1:0] right,
	output logic [DATA_WIDTH-1:0] data
);
	import iidl_pkg::*;

	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;
	logic at_pos;
	logic above_pos;

	assign at_pos = (pos == MY_IDX);
	assign above_pos = (MY_IDX > pos);

	// insert moves entries above the slot up, delete pulls them down
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (above_pos) begin
				data_q <= left;
			end else if (at_pos) begin
				data_q <= word;
			end
		end else if (ctrl.del) begin
			if (above_pos || at_pos) begin
				data_q <= right;
			end
		end else if (ctrl.wr) begin
			if (at_pos) begin
				data_q <= word;
			end
		end
	end

	assign data = data_q;

endmodule

FILE: tb/tb_indexed_insert_delete_list.sv
`timescale 1ns / 1ps
// testbench for the indexed insert/delete list: drives random request words
// against a shadow copy of the list; depends on iidl_pkg, iidl_if and the rtl
module tb_indexed_insert_delete_list;
	import iidl_pkg::*;

	localparam int LIST_DEPTH = DEPTH_DEF;
	localparam int TOTAL_WORDS = 1900;
	localparam int HOLD_CYCLES = 80;
	localparam int STUCK_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_MAX = 10;

	typedef enum int {TREND_GROW, TREND_SHRINK, TREND_MIXED} trend_t;

	typedef struct {
		logic signed [VAL_W-1:0] read_value;
		logic [CNT_W-1:0] count;
		logic [ST_W-1:0] status;
	} list_resp_t;

	// shadow list plus the queue of response words still owed by the block
	class list_scoreboard;
		logic signed [VAL_W-1:0] shadow_cells [LIST_DEPTH];
		int shadow_count;
		list_resp_t pending_responses [$];
		int failures;

		function new();
			shadow_count = 0;
			failures = 0;
		endfunction

		function int pending();
			return pending_responses.size();
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= REPORT_MAX) $display("%s", msg);
		endfunction

		// apply one accepted request to the shadow list and queue its response
		function void note_request(logic [MODE_W-1:0] mode, logic [POS_W-1:0] position,
				logic signed [VAL_W-1:0] value);
			list_resp_t resp;
			int p;
			int i;
			resp.read_value = '0;
			resp.status = ST_OK;
			p = position;
			if (mode == MODE_INSERT) begin
				// beyond-end check takes priority over the full check
				if (p > shadow_count) begin
					resp.status = ST_RANGE;
				end else if (shadow_count >= LIST_DEPTH) begin
					resp.status = ST_FULL;
				end else begin
					for (i = shadow_count; i > p; i--) shadow_cells[i] = shadow_cells[i-1];
					shadow_cells[p] = value;
					shadow_count++;
				end
			end else if (p >= shadow_count) begin
				resp.status = ST_RANGE;
			end else begin
				case (mode)
					MODE_DELETE: begin
						for (i = p; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
						shadow_count--;
					end
					MODE_READ: begin
						resp.read_value = shadow_cells[p];
					end
					default: begin
						shadow_cells[p] = value;
					end
				endcase
			end
			resp.count = CNT_W'(shadow_count);
			pending_responses.push_back(resp);
		endfunction

		// compare one accepted response word with the oldest one owed
		function void check_response(logic signed [VAL_W-1:0] read_value,
				logic [CNT_W-1:0] count, logic [ST_W-1:0] status);
			list_resp_t want;
			if (pending_responses.size() == 0) begin
				flag($sformatf("unexpected response word: read_value %0d count %0d status %0d",
					read_value, count, status));
				return;
			end
			want = pending_responses.pop_front();
			if (read_value !== want.read_value)
				flag($sformatf("read_value mismatch: expected %0d, got %0d",
					want.read_value, read_value));
			if (count !== want.count)
				flag($sformatf("count mismatch: expected %0d, got %0d", want.count, count));
			if (status !== want.status)
				flag($sformatf("status mismatch: expected %0d, got %0d", want.status, status));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic hold_off = 1'b0;
	int sent_words = 0;
	int stuck_cycles = 0;
	int rx_style = 0;
	int rx_left = 0;
	int rx_tick = 0;
	list_scoreboard sb;

	iidl_req_if req_ch ();
	iidl_rsp_if rsp_ch ();

	indexed_insert_delete_list #(
		.DEPTH(LIST_DEPTH),
		.DATA_WIDTH(DATA_WIDTH_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// monitor both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.mode, req_ch.position, req_ch.value);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.read_value, rsp_ch.count, rsp_ch.status);
		end
	end

	// watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// response side: changing stall styles, or a long hold-off on request
	always begin
		@(negedge clk);
		if (hold_off) begin
			rsp_ch.ready <= 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_off <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_style = $urandom_range(3);
				rx_left = $urandom_range(20, 120);
			end
			rx_left--;
			rx_tick++;
			case (rx_style)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= ($urandom_range(99) < 75);
				2: rsp_ch.ready <= ($urandom_range(99) < 30);
				default: rsp_ch.ready <= ((rx_tick % 8) < 5);
			endcase
		end
	end

	// offer one request word from a falling edge until it is taken
	task automatic send_item(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] p,
			input logic signed [VAL_W-1:0] v);
		req_ch.valid <= 1'b1;
		req_ch.mode <= m;
		req_ch.position <= p;
		req_ch.value <= v;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
		sent_words++;
	endtask

	task automatic pause_sender(input int n);
		req_ch.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// stop offering until every owed response has come back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	// bursts of random requests, mostly at valid positions, with a mode mix
	task automatic run_phase(input trend_t trend, input int n);
		int left;
		int burst;
		int roll;
		int cnt;
		int ins_pct;
		int del_pct;
		logic [MODE_W-1:0] m;
		logic [POS_W-1:0] p;
		logic signed [VAL_W-1:0] v;
		case (trend)
			TREND_GROW: begin
				ins_pct = 55;
				del_pct = 15;
			end
			TREND_SHRINK: begin
				ins_pct = 15;
				del_pct = 55;
			end
			default: begin
				ins_pct = 25;
				del_pct = 25;
			end
		endcase
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			if (burst > left) burst = left;
			left -= burst;
			repeat (burst) begin
				cnt = sb.shadow_count;
				roll = $urandom_range(99);
				if (roll < ins_pct) m = MODE_INSERT;
				else if (roll < ins_pct + del_pct) m = MODE_DELETE;
				else if (roll < ins_pct + del_pct + (100 - ins_pct - del_pct) / 2) m = MODE_READ;
				else m = MODE_WRITE;
				if ($urandom_range(99) < 85 && (m == MODE_INSERT || cnt > 0)) begin
					if (m == MODE_INSERT) p = POS_W'($urandom_range(cnt > 15 ? 15 : cnt));
					else p = POS_W'($urandom_range(cnt - 1));
				end else begin
					p = POS_W'($urandom_range(15));
				end
				case ($urandom_range(7))
					0: v = 32'sh7fff_ffff;
					1: v = 32'sh8000_0000;
					2: v = '0;
					3: v = '1;
					default: v = $urandom;
				endcase
				send_item(m, p, v);
			end
			if ($urandom_range(3) != 0) pause_sender($urandom_range(1, 8));
		end
	endtask

	initial begin
		int phase_no;
		sb = new();
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_INSERT;
		req_ch.position = '0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// empty list: every mode is out of range, insert past the end too
		send_item(MODE_READ, 0, '0);
		send_item(MODE_DELETE, 0, '0);
		send_item(MODE_WRITE, 0, 32'sh1234_5678);
		send_item(MODE_INSERT, 15, -1);
		// extremes at front, middle and an append at the count
		send_item(MODE_INSERT, 0, 32'sh7fff_ffff);
		send_item(MODE_INSERT, 0, 32'sh8000_0000);
		send_item(MODE_INSERT, 1, -1);
		send_item(MODE_INSERT, 3, '0);
		// fill to capacity
		while (sb.shadow_count < LIST_DEPTH)
			send_item(MODE_INSERT, POS_W'($urandom_range(sb.shadow_count)), $urandom);
		// full list: insert refused, last slot usable, then shrink
		send_item(MODE_INSERT, 15, 5);
		send_item(MODE_READ, 15, '0);
		send_item(MODE_WRITE, 15, 32'sh8000_0000);
		send_item(MODE_DELETE, 0, '0);
		send_item(MODE_READ, 15, '0);
		send_item(MODE_DELETE, 14, '0);
		wait_drained();

		// random phases with a long receiver hold and a full drain mixed in
		phase_no = 0;
		while (sent_words < TOTAL_WORDS) begin
			if (phase_no % 9 == 3) hold_off <= 1'b1;
			if (phase_no % 9 == 7) wait_drained();
			run_phase(trend_t'($urandom_range(2)), $urandom_range(40, 150));
			phase_no++;
		end

		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
rtl/iidl_pkg.sv
rtl/iidl_if.sv
rtl/iidl_cell.sv
rtl/indexed_insert_delete_list.sv
tb/tb_indexed_insert_delete_list.sv
